/* rtl/scb_pkg.sv */
`timescale 1ns / 1ps
package scb_pkg;

  localparam int COORD_BITS = 20;
  localparam int T_FRAC     = 20;
  localparam int CW         = COORD_BITS;
  localparam int DW         = CW + 1;
  localparam int RW         = CW - 1;
  localparam int LW         = CW + 1;
  localparam int TW         = T_FRAC + 1;
  localparam int SW         = 2 * CW + 2;
  localparam int ROOT_W     = SW / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int NDIV       = 8;
  localparam int NIT        = (ROOT_W > T_FRAC) ? ROOT_W : T_FRAC;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [RW-1:0] X_HALF_RESET  = RW'(63931);
  localparam logic [RW-1:0] Y_HALF_RESET  = RW'(51850);
  localparam logic [RW-1:0] Z_INNER_RESET = RW'(12680);
  localparam logic [RW-1:0] Z_OUTER_RESET = RW'(54320);

  localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC{1'b0}}};

  typedef enum logic [1:0] {
    REG_X_HALF  = 2'd0,
    REG_Y_HALF  = 2'd1,
    REG_Z_INNER = 2'd2,
    REG_Z_OUTER = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] pre_x;
    logic signed [CW-1:0] pre_y;
    logic signed [CW-1:0] pre_z;
    logic signed [CW-1:0] post_x;
    logic signed [CW-1:0] post_y;
    logic signed [CW-1:0] post_z;
  } in_t;

  typedef struct packed {
    logic                 has_piece;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_z;
    logic [LW-1:0]        piece_length;
    logic                 last;
  } out_t;

  typedef struct packed {
    logic [RW-1:0] x_half;
    logic [RW-1:0] y_half;
    logic [RW-1:0] z_inner;
    logic [RW-1:0] z_outer;
  } cfg_t;

  typedef struct packed {
    logic [2:0][CW-1:0] p;
    logic [2:0][DW-1:0] d;
    logic [ROOT_W-1:0]  chord;
    logic [1:0]         cnt;
    logic [1:0][TW-1:0] t0;
    logic [1:0][TW-1:0] t1;
  } qrec_t;

endpackage

/* rtl/scb_front.sv */
`timescale 1ns / 1ps
module scb_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          seg_valid,
  output logic          seg_stall,
  input  scb_pkg::in_t  seg,
  input  scb_pkg::cfg_t cfg,
  output logic          rec_valid,
  output scb_pkg::qrec_t rec,
  input  logic          rec_full
);

  localparam int CW = scb_pkg::CW;
  localparam int DW = scb_pkg::DW;
  localparam int TW = scb_pkg::TW;
  localparam int SW = scb_pkg::SW;
  localparam int ROOT_W = scb_pkg::ROOT_W;
  localparam int REM_W = scb_pkg::REM_W;
  localparam int NDIV = scb_pkg::NDIV;
  localparam int NIT = scb_pkg::NIT;
  localparam int T_FRAC = scb_pkg::T_FRAC;

  typedef struct packed {
    logic [CW-1:0]     r;
    logic [T_FRAC-1:0] q;
    logic [CW-1:0]     ud;
    logic              zero;
    logic              one;
  } div_t;

  typedef struct packed {
    logic [2:0][CW-1:0] p;
    logic [2:0][DW-1:0] d;
    logic [SW-1:0]      sum;
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
    div_t [NDIV-1:0]    dv;
    logic [2:0]         dzero;
    logic [3:0]         miss;
  } fr_t;

  function automatic fr_t fr_step(fr_t a, int k);
    fr_t o;
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    logic [CW:0]      r2;
    o = a;
    if (k < ROOT_W) begin
      rem2  = {a.rem[REM_W-3:0], a.sum[SW-1 -: 2]};
      trial = REM_W'({a.root, 2'b01});
      o.sum = a.sum << 2;
      if (rem2 >= trial) begin
        o.rem  = rem2 - trial;
        o.root = {a.root[ROOT_W-2:0], 1'b1};
      end else begin
        o.rem  = rem2;
        o.root = {a.root[ROOT_W-2:0], 1'b0};
      end
    end
    if (k < T_FRAC) begin
      for (int j = 0; j < NDIV; j++) begin
        r2 = {a.dv[j].r, 1'b0};
        if (r2 >= {1'b0, a.dv[j].ud}) begin
          o.dv[j].r = CW'(r2 - {1'b0, a.dv[j].ud});
          o.dv[j].q = {a.dv[j].q[T_FRAC-2:0], 1'b1};
        end else begin
          o.dv[j].r = r2[CW-1:0];
          o.dv[j].q = {a.dv[j].q[T_FRAC-2:0], 1'b0};
        end
      end
    end
    return o;
  endfunction

  function automatic logic signed [DW-1:0] face_n(logic [scb_pkg::RW-1:0] m, logic neg,
                                                 logic signed [CW-1:0] p);
    logic signed [DW-1:0] f;
    f = $signed({2'b00, m});
    return (neg ? -f : f) - DW'(p);
  endfunction

  function automatic logic [DW-1:0] mag(logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  logic adv;
  assign adv = !(rec_valid && rec_full);
  assign seg_stall = !adv;

  logic signed [DW-1:0] n_c [NDIV];
  logic signed [DW-1:0] d_c [3];

  always_comb begin
    d_c[0] = DW'(seg.post_x) - DW'(seg.pre_x);
    d_c[1] = DW'(seg.post_y) - DW'(seg.pre_y);
    d_c[2] = DW'(seg.post_z) - DW'(seg.pre_z);
    n_c[0] = face_n(cfg.x_half, 1'b1, seg.pre_x);
    n_c[1] = face_n(cfg.x_half, 1'b0, seg.pre_x);
    n_c[2] = face_n(cfg.y_half, 1'b1, seg.pre_y);
    n_c[3] = face_n(cfg.y_half, 1'b0, seg.pre_y);
    n_c[4] = face_n(cfg.z_outer, 1'b1, seg.pre_z);
    n_c[5] = face_n(cfg.z_inner, 1'b1, seg.pre_z);
    n_c[6] = face_n(cfg.z_inner, 1'b0, seg.pre_z);
    n_c[7] = face_n(cfg.z_outer, 1'b0, seg.pre_z);
  end

  logic                 a_valid;
  logic signed [CW-1:0] a_p [3];
  logic signed [DW-1:0] a_d [3];
  logic signed [DW-1:0] a_n [NDIV];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= seg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_p[0] <= seg.pre_x;
      a_p[1] <= seg.pre_y;
      a_p[2] <= seg.pre_z;
      for (int i = 0; i < 3; i++) a_d[i] <= d_c[i];
      for (int i = 0; i < NDIV; i++) a_n[i] <= n_c[i];
    end
  end

  fr_t b_c;
  logic [CW-1:0] md [3];
  logic [DW-1:0] mn;
  int ax;

  always_comb begin
    b_c = '0;
    for (int i = 0; i < 3; i++) begin
      md[i]       = CW'(mag(a_d[i]));
      b_c.p[i]    = a_p[i];
      b_c.d[i]    = a_d[i];
      b_c.dzero[i] = (a_d[i] == '0);
    end
    b_c.sum = SW'(md[0] * md[0]) + SW'(md[1] * md[1]) + SW'(md[2] * md[2]);
    for (int i = 0; i < NDIV; i++) begin
      ax = (i < 2) ? 0 : ((i < 4) ? 1 : 2);
      mn = mag(a_n[i]);
      b_c.dv[i].ud   = md[ax];
      b_c.dv[i].zero = (a_n[i] == '0) || (a_n[i][DW-1] != a_d[ax][DW-1]);
      b_c.dv[i].one  = !b_c.dv[i].zero && (mn >= {1'b0, md[ax]});
      b_c.dv[i].r    = mn[CW-1:0];
    end
    b_c.miss[0] = b_c.dzero[0] && (a_n[0] > 0 || a_n[1] < 0);
    b_c.miss[1] = b_c.dzero[1] && (a_n[2] > 0 || a_n[3] < 0);
    b_c.miss[2] = b_c.dzero[2] && (a_n[4] > 0 || a_n[5] < 0);
    b_c.miss[3] = b_c.dzero[2] && (a_n[6] > 0 || a_n[7] < 0);
  end

  logic b_valid;
  fr_t  b;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b <= b_c;
    end
  end

  fr_t  it [NIT];
  logic [NIT-1:0] it_valid;

  for (genvar k = 0; k < NIT; k++) begin : g_it
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          it_valid[k] <= 1'b0;
        end else if (adv) begin
          it_valid[k] <= b_valid;
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          it[k] <= fr_step(b, k);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rst) begin
          it_valid[k] <= 1'b0;
        end else if (adv) begin
          it_valid[k] <= it_valid[k-1];
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          it[k] <= fr_step(it[k-1], k);
        end
      end
    end
  end

  fr_t             x;
  logic [TW-1:0]   t [NDIV];
  logic [TW-1:0]   lo_t [2];
  logic [TW-1:0]   hi_t [2];
  logic [TW-1:0]   ta;
  logic [TW-1:0]   tb;
  logic [1:0]      ok;
  int              f0;
  scb_pkg::qrec_t  cls;

  always_comb begin
    x = it[NIT-1];
    for (int i = 0; i < NDIV; i++) begin
      t[i] = x.dv[i].zero ? '0 : (x.dv[i].one ? scb_pkg::T_ONE : TW'(x.dv[i].q));
    end
    for (int bx = 0; bx < 2; bx++) begin
      lo_t[bx] = '0;
      hi_t[bx] = scb_pkg::T_ONE;
      for (int a = 0; a < 3; a++) begin
        f0 = (a == 2) ? (4 + 2 * bx) : (2 * a);
        ta = (t[f0] < t[f0+1]) ? t[f0] : t[f0+1];
        tb = (t[f0] < t[f0+1]) ? t[f0+1] : t[f0];
        if (!x.dzero[a]) begin
          if (ta > lo_t[bx]) lo_t[bx] = ta;
          if (tb < hi_t[bx]) hi_t[bx] = tb;
        end
      end
      ok[bx] = !(cfg.z_inner > cfg.z_outer) && !x.miss[0] && !x.miss[1] &&
               !x.miss[2+bx] && (hi_t[bx] > lo_t[bx]) && (x.root != '0);
    end
    cls.p     = x.p;
    cls.d     = x.d;
    cls.chord = x.root;
    cls.cnt   = {1'b0, ok[0]} + {1'b0, ok[1]};
    cls.t0    = '0;
    cls.t1    = '0;
    priority if (ok[0] && ok[1] && (lo_t[1] < lo_t[0])) begin
      cls.t0[0] = lo_t[1]; cls.t1[0] = hi_t[1];
      cls.t0[1] = lo_t[0]; cls.t1[1] = hi_t[0];
    end else if (ok[0]) begin
      cls.t0[0] = lo_t[0]; cls.t1[0] = hi_t[0];
      cls.t0[1] = lo_t[1]; cls.t1[1] = hi_t[1];
    end else begin
      cls.t0[0] = lo_t[1]; cls.t1[0] = hi_t[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (adv) begin
      rec_valid <= it_valid[NIT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rec <= cls;
    end
  end

endmodule

/* rtl/scb_fifo.sv */
`timescale 1ns / 1ps
module scb_fifo #(
  parameter int DEPTH = scb_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  scb_pkg::qrec_t din,
  output logic           full,
  input  logic           pop,
  output scb_pkg::qrec_t dout,
  output logic           empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  scb_pkg::qrec_t mem [DEPTH];
  logic [AW-1:0]  wptr;
  logic [AW-1:0]  rptr;
  logic [CNW-1:0] count;

  assign full  = (count == CNW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CNW'(push && !full) - CNW'(pop && !empty);
    end
  end

endmodule

/* rtl/scb_back.sv */
`timescale 1ns / 1ps
module scb_back (
  input  logic           clk,
  input  logic           rst,
  input  scb_pkg::qrec_t head,
  input  logic           empty,
  output logic           pop,
  output logic           piece_valid,
  input  logic           piece_stall,
  output scb_pkg::out_t  piece
);

  localparam int CW = scb_pkg::CW;
  localparam int DW = scb_pkg::DW;
  localparam int TW = scb_pkg::TW;
  localparam int LW = scb_pkg::LW;
  localparam int ROOT_W = scb_pkg::ROOT_W;
  localparam int T_FRAC = scb_pkg::T_FRAC;
  localparam int PW = TW + CW;
  localparam int LPW = TW + ROOT_W;
  localparam int VW = LPW + 1 - T_FRAC;

  logic en;
  logic issue;
  logic idx;
  logic idx_next;
  logic last_c;
  logic [TW-1:0] t0_c;
  logic [TW-1:0] t1_c;
  logic [CW-1:0] md [3];

  assign en    = !(piece_valid && piece_stall);
  assign issue = en && !empty;

  always_comb begin
    t0_c = head.t0[idx];
    t1_c = head.t1[idx];
    for (int i = 0; i < 3; i++) begin
      md[i] = head.d[i][DW-1] ? CW'(-$signed(head.d[i])) : head.d[i][CW-1:0];
    end
    if (head.cnt == 2'd2 && !idx) begin
      last_c   = 1'b0;
      idx_next = 1'b1;
    end else begin
      last_c   = 1'b1;
      idx_next = 1'b0;
    end
    pop = issue && last_c;
  end

  logic               m_valid;
  logic               m_has;
  logic               m_last;
  logic [2:0][CW-1:0] m_p;
  logic [2:0]         m_neg;
  logic [PW-1:0]      m_ps [3];
  logic [PW-1:0]      m_pe [3];
  logic [LPW-1:0]     m_pl;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      idx     <= 1'b0;
    end else if (en) begin
      m_valid <= !empty;
      if (!empty) idx <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      m_has  <= (head.cnt != 2'd0);
      m_last <= last_c;
      m_p    <= head.p;
      for (int i = 0; i < 3; i++) begin
        m_neg[i] <= head.d[i][DW-1];
        m_ps[i]  <= PW'(t0_c) * PW'(md[i]);
        m_pe[i]  <= PW'(t1_c) * PW'(md[i]);
      end
      m_pl <= LPW'(t1_c - t0_c) * LPW'(head.chord);
    end
  end

  function automatic logic [CW-1:0] point(logic [CW-1:0] p, logic neg, logic [PW-1:0] prod);
    logic [PW:0]          s;
    logic [CW-1:0]        m;
    logic signed [DW-1:0] off;
    logic signed [DW-1:0] r;
    s   = {1'b0, prod} + ((PW+1)'(1) << (T_FRAC - 1));
    m   = s[T_FRAC +: CW];
    off = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    r   = DW'($signed(p)) + off;
    return r[CW-1:0];
  endfunction

  scb_pkg::out_t o_c;
  logic [LPW:0]  ls;
  logic [VW-1:0] lv;

  always_comb begin
    ls = {1'b0, m_pl} + ((LPW+1)'(1) << (T_FRAC - 1));
    lv = ls[LPW:T_FRAC];
    o_c = '0;
    o_c.last = m_last;
    if (m_has) begin
      o_c.has_piece    = 1'b1;
      o_c.start_x      = point(m_p[0], m_neg[0], m_ps[0]);
      o_c.start_y      = point(m_p[1], m_neg[1], m_ps[1]);
      o_c.start_z      = point(m_p[2], m_neg[2], m_ps[2]);
      o_c.end_x        = point(m_p[0], m_neg[0], m_pe[0]);
      o_c.end_y        = point(m_p[1], m_neg[1], m_pe[1]);
      o_c.end_z        = point(m_p[2], m_neg[2], m_pe[2]);
      o_c.piece_length = (lv > VW'({LW{1'b1}})) ? {LW{1'b1}} : lv[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      piece_valid <= 1'b0;
    end else if (en) begin
      piece_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && m_valid) begin
      piece <= o_c;
    end
  end

endmodule

/* rtl/segment_clip_two_boxes.sv */
`timescale 1ns / 1ps
// channel | direction | handshake                 | payload
// seg     | in        | seg_valid / seg_stall     | in_t: pre and post points
// piece   | out       | piece_valid / piece_stall | out_t: one clipped piece or none
// wr      | in        | wr_en                     | wr_index, wr_data
// The front takes one segment per cycle unless stalled, through a 24-stage
// pipeline: delta and face offsets, squared chord, then one root bit and one
// quotient bit per stage. The back sends one result per cycle while not stalled
// and the queue is not empty; one per item, or two when it crosses both boxes.
// Reset is synchronous and clears all valids and queue pointers.
// A stalled piece channel holds the back; the queue then fills and the front stalls.
module segment_clip_two_boxes #(
  parameter int QUEUE_DEPTH = scb_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  seg_valid,
  output logic                  seg_stall,
  input  scb_pkg::in_t          seg,
  output logic                  piece_valid,
  input  logic                  piece_stall,
  output scb_pkg::out_t         piece,
  input  logic                  wr_en,
  input  logic [1:0]            wr_index,
  input  logic [scb_pkg::RW-1:0] wr_data
);

  scb_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_half  <= scb_pkg::X_HALF_RESET;
      cfg.y_half  <= scb_pkg::Y_HALF_RESET;
      cfg.z_inner <= scb_pkg::Z_INNER_RESET;
      cfg.z_outer <= scb_pkg::Z_OUTER_RESET;
    end else if (wr_en) begin
      unique case (scb_pkg::reg_idx_t'(wr_index))
        scb_pkg::REG_X_HALF:  cfg.x_half  <= wr_data;
        scb_pkg::REG_Y_HALF:  cfg.y_half  <= wr_data;
        scb_pkg::REG_Z_INNER: cfg.z_inner <= wr_data;
        scb_pkg::REG_Z_OUTER: cfg.z_outer <= wr_data;
        default: ;
      endcase
    end
  end

  logic           rec_valid;
  scb_pkg::qrec_t rec;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  scb_pkg::qrec_t q_head;

  scb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .seg_valid (seg_valid),
    .seg_stall (seg_stall),
    .seg       (seg),
    .cfg       (cfg),
    .rec_valid (rec_valid),
    .rec       (rec),
    .rec_full  (q_full)
  );

  scb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (rec_valid),
    .din   (rec),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  scb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .empty       (q_empty),
    .pop         (q_pop),
    .piece_valid (piece_valid),
    .piece_stall (piece_stall),
    .piece       (piece)
  );

endmodule
